FILE: hw/rtl/lec_pkg.sv
// Shared types and constants for the lightmap extent calculator.
package lec_pkg;

  localparam int DEF_MAX_EXTENT  = 512;
  localparam int DEF_LUXEL_SHIFT = 4;

  // Middle queue between projection front and tracking back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam int ODEPTH = 2;

  localparam logic signed [28:0] SENTINEL = 29'sd256000000;
  localparam logic signed [30:0] Q8_MAX   = 31'sd268435455;
  localparam logic signed [30:0] Q8_MIN   = -31'sd268435456;

  // Configuration register indexes
  localparam logic [7:0] REG_S_AX  = 8'd0;
  localparam logic [7:0] REG_S_AY  = 8'd1;
  localparam logic [7:0] REG_S_AZ  = 8'd2;
  localparam logic [7:0] REG_S_OFF = 8'd3;
  localparam logic [7:0] REG_T_AX  = 8'd4;
  localparam logic [7:0] REG_T_AY  = 8'd5;
  localparam logic [7:0] REG_T_AZ  = 8'd6;
  localparam logic [7:0] REG_T_OFF = 8'd7;

  typedef struct packed {
    logic skip;
    logic last;
    logic bad;
  } flags_t;

  // One projected vertex on its way to the trackers
  typedef struct packed {
    logic signed [28:0] s;
    logic signed [28:0] t;
    flags_t             flags;
  } vtx_t;

  // Final bounds of one face, waiting for the extent stage
  typedef struct packed {
    logic signed [28:0] s_lo;
    logic signed [28:0] s_hi;
    logic signed [28:0] t_lo;
    logic signed [28:0] t_hi;
    logic               bad;
  } bounds_t;

  typedef struct packed {
    logic [9:0]         map_width;
    logic [9:0]         map_height;
    logic signed [28:0] min_s;
    logic signed [28:0] min_t;
  } res_t;

endpackage

FILE: hw/rtl/lec_front.sv
// Front end: configuration registers and the three-stage projection pipeline.
module lec_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [23:0]       vert_x,
  input  logic signed [23:0]       vert_y,
  input  logic signed [23:0]       vert_z,
  input  logic                     vertex_skip,
  input  logic                     face_invalid,
  input  logic                     last_vertex,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_index,
  input  logic [23:0]              cfg_data,
  input  logic [lec_pkg::CNT_W-1:0] q_count,
  output logic                     q_push,
  output lec_pkg::vtx_t            q_data
);
  import lec_pkg::*;

  logic signed [15:0] s_ax, s_ay, s_az, t_ax, t_ay, t_az;
  logic signed [23:0] s_off, t_off;

  logic v1, v2, v3;
  logic signed [39:0] p_sx, p_sy, p_sz, p_tx, p_ty, p_tz;
  flags_t f1, f2;
  logic signed [29:0] s2, t2;
  vtx_t st3;

  logic signed [41:0] s_sum, t_sum;
  logic [CNT_W:0] occ;
  logic acc;

  function automatic logic signed [28:0] sat_add(input logic signed [29:0] v,
                                                 input logic signed [23:0] off);
    logic signed [30:0] r;
    r = 31'(v) + 31'(off);
    if (r > Q8_MAX) begin
      return Q8_MAX[28:0];
    end else if (r < Q8_MIN) begin
      return Q8_MIN[28:0];
    end
    return r[28:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ax  <= '0;
      s_ay  <= '0;
      s_az  <= '0;
      s_off <= '0;
      t_ax  <= '0;
      t_ay  <= '0;
      t_az  <= '0;
      t_off <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_S_AX:  s_ax  <= cfg_data[15:0];
        REG_S_AY:  s_ay  <= cfg_data[15:0];
        REG_S_AZ:  s_az  <= cfg_data[15:0];
        REG_S_OFF: s_off <= cfg_data;
        REG_T_AX:  t_ax  <= cfg_data[15:0];
        REG_T_AY:  t_ay  <= cfg_data[15:0];
        REG_T_AZ:  t_az  <= cfg_data[15:0];
        REG_T_OFF: t_off <= cfg_data;
        default: ;
      endcase
    end
  end

  // Credit check: every item in flight has a queue slot reserved
  assign occ  = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(v1) + (CNT_W + 1)'(v2)
              + (CNT_W + 1)'(v3);
  assign full = occ >= (CNT_W + 1)'(QDEPTH);
  assign acc  = push && !full;

  assign s_sum = 42'(p_sx) + 42'(p_sy) + 42'(p_sz);
  assign t_sum = 42'(p_tx) + 42'(p_ty) + 42'(p_tz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p_sx <= vert_x * s_ax;
    p_sy <= vert_y * s_ay;
    p_sz <= vert_z * s_az;
    p_tx <= vert_x * t_ax;
    p_ty <= vert_y * t_ay;
    p_tz <= vert_z * t_az;
    f1   <= '{skip: vertex_skip, last: last_vertex, bad: face_invalid};
    // dropping the low 12 bits of a two's complement sum floors it
    s2   <= s_sum[41:12];
    t2   <= t_sum[41:12];
    f2   <= f1;
    st3.s     <= sat_add(s2, s_off);
    st3.t     <= sat_add(t2, t_off);
    st3.flags <= f2;
  end

  assign q_push = v3;
  assign q_data = st3;

endmodule

FILE: hw/rtl/lec_queue.sv
// Short queue between the projection front and the tracking back end.
module lec_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  lec_pkg::vtx_t             wr_data,
  input  logic                      rd,
  output lec_pkg::vtx_t             rd_data,
  output logic                      empty,
  output logic [lec_pkg::CNT_W-1:0] count
);
  import lec_pkg::*;

  vtx_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(wr) - CNT_W'(rd);
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = count == '0;

endmodule

FILE: hw/rtl/lec_back.sv
// Back end: min/max trackers, extent arithmetic and the result queue.
module lec_back #(
  parameter int MAX_EXTENT  = lec_pkg::DEF_MAX_EXTENT,
  parameter int LUXEL_SHIFT = lec_pkg::DEF_LUXEL_SHIFT
) (
  input  logic          clk,
  input  logic          rst,
  input  lec_pkg::vtx_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output lec_pkg::res_t res,
  output logic          empty,
  input  logic          pop
);
  import lec_pkg::*;

  localparam int K         = LUXEL_SHIFT + 8;
  localparam int LUX_ROUND = (1 << K) - 1;

  logic signed [28:0] s_low, s_high, t_low, t_high;
  logic signed [28:0] s_low_next, s_high_next, t_low_next, t_high_next;

  bounds_t bnd;
  logic    bnd_valid, bnd_adv, bnd_free, head_emits;

  res_t   omem [ODEPTH];
  logic   o_wr_ptr, o_rd_ptr;
  logic [1:0] o_count;
  logic   o_full, o_pop;
  res_t   o_entry;

  function automatic logic [9:0] extent(input logic signed [28:0] lo,
                                        input logic signed [28:0] hi);
    logic signed [29:0] hi_up;
    logic signed [29:0] c;
    logic signed [29:0] f;
    logic signed [30:0] n;
    hi_up = 30'(hi) + 30'(LUX_ROUND);
    c = hi_up >>> K;
    f = 30'(lo) >>> K;
    n = 31'(c) - 31'(f) + 31'sd1;
    if (n < 31'sd1) begin
      n = 31'sd1;
    end else if (n > 31'(MAX_EXTENT)) begin
      n = 31'(MAX_EXTENT);
    end
    return n[9:0];
  endfunction

  // Only the final vertex of a face or an invalid-face request needs room in the bounds register
  assign head_emits = head.flags.last || head.flags.bad;
  assign o_full     = o_count == 2'(ODEPTH);
  assign o_pop      = pop && !empty;
  assign bnd_adv    = bnd_valid && (!o_full || o_pop);
  assign bnd_free   = !bnd_valid || bnd_adv;
  assign q_pop      = !q_empty && (!head_emits || bnd_free);

  always_comb begin
    s_low_next  = s_low;
    s_high_next = s_high;
    t_low_next  = t_low;
    t_high_next = t_high;
    if (!head.flags.skip) begin
      if (head.s < s_low)  s_low_next  = head.s;
      if (head.s > s_high) s_high_next = head.s;
      if (head.t < t_low)  t_low_next  = head.t;
      if (head.t > t_high) t_high_next = head.t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_low  <= SENTINEL;
      s_high <= -SENTINEL;
      t_low  <= SENTINEL;
      t_high <= -SENTINEL;
    end else if (q_pop) begin
      if (head_emits) begin
        s_low  <= SENTINEL;
        s_high <= -SENTINEL;
        t_low  <= SENTINEL;
        t_high <= -SENTINEL;
      end else begin
        s_low  <= s_low_next;
        s_high <= s_high_next;
        t_low  <= t_low_next;
        t_high <= t_high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_valid <= 1'b0;
    end else if (q_pop && head_emits) begin
      bnd_valid <= 1'b1;
    end else if (bnd_adv) begin
      bnd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head_emits) begin
      bnd.s_lo <= s_low_next;
      bnd.s_hi <= s_high_next;
      bnd.t_lo <= t_low_next;
      bnd.t_hi <= t_high_next;
      bnd.bad  <= head.flags.bad;
    end
  end

  always_comb begin
    if (bnd.bad) begin
      o_entry = '{map_width: 10'd1, map_height: 10'd1, min_s: '0, min_t: '0};
    end else begin
      o_entry.map_width  = extent(bnd.s_lo, bnd.s_hi);
      o_entry.map_height = extent(bnd.t_lo, bnd.t_hi);
      o_entry.min_s      = bnd.s_lo;
      o_entry.min_t      = bnd.t_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_adv) begin
      omem[o_wr_ptr] <= o_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr_ptr <= 1'b0;
      o_rd_ptr <= 1'b0;
      o_count  <= '0;
    end else begin
      if (bnd_adv) o_wr_ptr <= !o_wr_ptr;
      if (o_pop)   o_rd_ptr <= !o_rd_ptr;
      o_count <= o_count + 2'(bnd_adv) - 2'(o_pop);
    end
  end

  assign res   = omem[o_rd_ptr];
  assign empty = o_count == 2'd0;

endmodule

FILE: hw/rtl/lightmap_extent_calculator_top.sv
// Top level of the lightmap extent calculator.
// Takes one polygon vertex per cycle when full is low. A vertex is projected
// in a three-stage pipeline (products, sum, offset and saturation), waits in
// an eight-entry queue, and updates the min/max trackers; the final vertex of
// a face (or an invalid-face request) then goes through one extent stage into
// a two-entry result queue. Sustained rate is one vertex per cycle unless the
// result queue is full and holds back a face's final vertex. Configuration
// writes are always accepted (cfg_ready is tied high); indexes above seven are
// ignored.
module lightmap_extent_calculator_top #(
  parameter int MAX_EXTENT  = lec_pkg::DEF_MAX_EXTENT,
  parameter int LUXEL_SHIFT = lec_pkg::DEF_LUXEL_SHIFT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] vert_x,
  input  logic signed [23:0] vert_y,
  input  logic signed [23:0] vert_z,
  input  logic               vertex_skip,
  input  logic               face_invalid,
  input  logic               last_vertex,
  output logic               empty,
  input  logic               pop,
  output logic [9:0]         map_width,
  output logic [9:0]         map_height,
  output logic signed [28:0] min_s_out,
  output logic signed [28:0] min_t_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import lec_pkg::*;

  logic            q_push, q_pop, q_empty;
  vtx_t            q_wr_data, q_head;
  logic [CNT_W-1:0] q_count;
  res_t            res;

  lec_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .vert_x       (vert_x),
    .vert_y       (vert_y),
    .vert_z       (vert_z),
    .vertex_skip  (vertex_skip),
    .face_invalid (face_invalid),
    .last_vertex  (last_vertex),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  lec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty),
    .count   (q_count)
  );

  lec_back #(
    .MAX_EXTENT  (MAX_EXTENT),
    .LUXEL_SHIFT (LUXEL_SHIFT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign map_width  = res.map_width;
  assign map_height = res.map_height;
  assign min_s_out  = res.min_s;
  assign min_t_out  = res.min_t;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the lightmap extent calculator: directed and random faces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lec_pkg::*;

  localparam int     LUX_SHIFT = DEF_LUXEL_SHIFT + 8;
  localparam longint SAT_HI    = 268435455;
  localparam longint SAT_LO    = -268435456;
  localparam logic signed [23:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [23:0] COORD_MIN = 24'sh800000;
  localparam int     SPREAD    = 32768;
  localparam int     SETTLE    = 20;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               skip;
    logic               bad;
    logic               last;
  } vertex_t;

  typedef logic [23:0] setting_t [8];

  // Tracks texture-space bounds per face and holds the extents still due
  class extent_tracker;
    logic signed [15:0] s_axis [3];
    logic signed [15:0] t_axis [3];
    logic signed [23:0] s_off;
    logic signed [23:0] t_off;
    logic signed [28:0] s_low, s_high, t_low, t_high;
    res_t               due_extents [$];
    int                 mismatches;
    int                 extents_seen;

    function new();
      foreach (s_axis[i]) begin
        s_axis[i] = '0;
        t_axis[i] = '0;
      end
      s_off = '0;
      t_off = '0;
      mismatches = 0;
      extents_seen = 0;
      restart_bounds();
    endfunction

    function void restart_bounds();
      s_low  = SENTINEL;
      s_high = -SENTINEL;
      t_low  = SENTINEL;
      t_high = -SENTINEL;
    endfunction

    function void write_reg(logic [7:0] idx, logic [23:0] data);
      case (idx)
        REG_S_AX:  s_axis[0] = data[15:0];
        REG_S_AY:  s_axis[1] = data[15:0];
        REG_S_AZ:  s_axis[2] = data[15:0];
        REG_S_OFF: s_off     = data;
        REG_T_AX:  t_axis[0] = data[15:0];
        REG_T_AY:  t_axis[1] = data[15:0];
        REG_T_AZ:  t_axis[2] = data[15:0];
        REG_T_OFF: t_off     = data;
        default: ;
      endcase
    endfunction

    // Dot product in Q.20, floored to Q.8, offset added, saturated to 29 bits
    function logic signed [28:0] project(vertex_t v, logic signed [15:0] a0,
                                         logic signed [15:0] a1, logic signed [15:0] a2,
                                         logic signed [23:0] off);
      longint dot;
      dot = longint'(v.x) * longint'(a0) + longint'(v.y) * longint'(a1)
          + longint'(v.z) * longint'(a2);
      dot = (dot >>> 12) + longint'(off);
      if (dot > SAT_HI) dot = SAT_HI;
      if (dot < SAT_LO) dot = SAT_LO;
      return dot[28:0];
    endfunction

    function logic [9:0] luxels(logic signed [28:0] lo, logic signed [28:0] hi);
      longint n;
      n = -((-longint'(hi)) >>> LUX_SHIFT) - (longint'(lo) >>> LUX_SHIFT) + 1;
      if (n < 1) n = 1;
      if (n > DEF_MAX_EXTENT) n = DEF_MAX_EXTENT;
      return n[9:0];
    endfunction

    function void take_vertex(vertex_t v);
      logic signed [28:0] s, t;
      res_t               r;
      if (v.bad) begin
        r.map_width  = 10'd1;
        r.map_height = 10'd1;
        r.min_s      = '0;
        r.min_t      = '0;
        due_extents.insert(due_extents.size(), r);
        restart_bounds();
        return;
      end
      if (!v.skip) begin
        s = project(v, s_axis[0], s_axis[1], s_axis[2], s_off);
        t = project(v, t_axis[0], t_axis[1], t_axis[2], t_off);
        if (s < s_low) s_low = s;
        if (s > s_high) s_high = s;
        if (t < t_low) t_low = t;
        if (t > t_high) t_high = t;
      end
      if (v.last) begin
        r.map_width  = luxels(s_low, s_high);
        r.map_height = luxels(t_low, t_high);
        r.min_s      = s_low;
        r.min_t      = t_low;
        due_extents.insert(due_extents.size(), r);
        restart_bounds();
      end
    endfunction

    function void match_extent(res_t got);
      res_t want;
      extents_seen++;
      if (due_extents.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected extent w=%0d h=%0d s=%0d t=%0d", $time,
                   got.map_width, got.map_height, $signed(got.min_s), $signed(got.min_t));
        return;
      end
      want = due_extents.pop_front();
      if (got.map_width !== want.map_width || got.map_height !== want.map_height ||
          got.min_s !== want.min_s || got.min_t !== want.min_t) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: extent mismatch: want w=%0d h=%0d s=%0d t=%0d, got w=%0d h=%0d s=%0d t=%0d",
                   $time, want.map_width, want.map_height, $signed(want.min_s),
                   $signed(want.min_t), got.map_width, got.map_height,
                   $signed(got.min_s), $signed(got.min_t));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [23:0] vert_x = '0;
  logic signed [23:0] vert_y = '0;
  logic signed [23:0] vert_z = '0;
  logic               vertex_skip = 1'b0;
  logic               face_invalid = 1'b0;
  logic               last_vertex = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [9:0]         map_width;
  logic [9:0]         map_height;
  logic signed [28:0] min_s_out;
  logic signed [28:0] min_t_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  extent_tracker board;
  res_t          extent_out;
  bit            calm = 1'b0;
  int            items_sent = 0;
  int            settings_used = 0;

  lightmap_extent_calculator_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .vert_x       (vert_x),
    .vert_y       (vert_y),
    .vert_z       (vert_z),
    .vertex_skip  (vertex_skip),
    .face_invalid (face_invalid),
    .last_vertex  (last_vertex),
    .empty        (empty),
    .pop          (pop),
    .map_width    (map_width),
    .map_height   (map_height),
    .min_s_out    (min_s_out),
    .min_t_out    (min_t_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      extent_out.map_width  = map_width;
      extent_out.map_height = map_height;
      extent_out.min_s      = min_s_out;
      extent_out.min_t      = min_t_out;
      board.match_extent(extent_out);
    end
  end

  // Result side stalls in bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !calm && $urandom_range(0, 7) == 0)
        hold = $urandom_range(1, 15);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic vertex_t vtx(logic signed [23:0] x, logic signed [23:0] y,
                                  logic signed [23:0] z, bit skip, bit bad, bit last);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.skip = skip;
    v.bad = bad;
    v.last = last;
    return v;
  endfunction

  function automatic logic signed [23:0] near(logic signed [23:0] c);
    return c + 24'($urandom_range(0, 2 * SPREAD)) - 24'(SPREAD);
  endfunction

  function automatic setting_t unit_setting();
    setting_t st;
    foreach (st[i]) st[i] = '0;
    st[REG_S_AX] = 24'd4096;
    st[REG_T_AY] = 24'd4096;
    return st;
  endfunction

  function automatic setting_t extreme_setting(bit flip);
    setting_t st;
    logic [23:0] ax_a, ax_b, off_a, off_b;
    ax_a  = flip ? 24'hff8000 : 24'h007fff;
    ax_b  = flip ? 24'h007fff : 24'hff8000;
    off_a = flip ? 24'h800000 : 24'h7fffff;
    off_b = flip ? 24'h7fffff : 24'h800000;
    st[REG_S_AX]  = ax_a;
    st[REG_S_AY]  = ax_a;
    st[REG_S_AZ]  = ax_a;
    st[REG_S_OFF] = off_a;
    st[REG_T_AX]  = ax_b;
    st[REG_T_AY]  = ax_b;
    st[REG_T_AZ]  = ax_b;
    st[REG_T_OFF] = off_b;
    return st;
  endfunction

  // narrow: axes within +-2.0 and offsets within +-1024 units; else raw bits
  function automatic setting_t random_setting(bit narrow);
    setting_t st;
    foreach (st[i]) begin
      if (!narrow)
        st[i] = 24'($urandom);
      else if (i == REG_S_OFF || i == REG_T_OFF)
        st[i] = 24'($urandom_range(0, 524288)) - 24'd262144;
      else
        st[i] = 24'($urandom_range(0, 16384)) - 24'd8192;
    end
    return st;
  endfunction

  // Entered and left at a falling edge; push stays high between back-to-back requests
  task automatic send_vertex(vertex_t v);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push         <= 1'b1;
    vert_x       <= v.x;
    vert_y       <= v.y;
    vert_z       <= v.z;
    vertex_skip  <= v.skip;
    face_invalid <= v.bad;
    last_vertex  <= v.last;
    @(posedge clk);
    while (full) @(posedge clk);
    board.take_vertex(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Wait for every due extent, then let non-result requests clear the pipeline
  task automatic drain();
    push <= 1'b0;
    while (board.due_extents.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_regs(setting_t st, bit stray);
    logic [7:0]  idx;
    logic [23:0] val;
    int          top;
    top = stray ? REG_T_OFF + 1 : REG_T_OFF;
    for (int i = 0; i <= top; i++) begin
      // out-of-range index must leave the registers alone
      idx = (i <= REG_T_OFF) ? 8'(i) : 8'($urandom_range(REG_T_OFF + 1, 255));
      val = (i <= REG_T_OFF) ? st[i] : 24'($urandom);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_reg(idx, val);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_face(bit wide);
    int                 n;
    vertex_t            v;
    logic signed [23:0] cx, cy, cz;
    n  = $urandom_range(1, 8);
    cx = 24'($urandom);
    cy = 24'($urandom);
    cz = 24'($urandom);
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        v.x = 24'($urandom);
        v.y = 24'($urandom);
        v.z = 24'($urandom);
      end else begin
        v.x = near(cx);
        v.y = near(cy);
        v.z = near(cz);
      end
      v.skip = ($urandom_range(0, 9) == 0);
      v.bad  = ($urandom_range(0, 39) == 0);
      v.last = (i == n - 1);
      send_vertex(v);
    end
  endtask

  task automatic random_run(int count);
    int      start;
    int      pick;
    vertex_t v;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        // noise: any bit pattern, including stray flags
        v = vtx(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)),
                $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        send_vertex(v);
      end else begin
        random_face(pick < 6);
      end
    end
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: empty face gives sentinels, invalid face gives the default
    send_vertex(vtx(COORD_MAX, COORD_MIN, 24'sd5, 1'b1, 1'b0, 1'b1));
    send_vertex(vtx(24'sd77, 24'sd0, COORD_MAX, 1'b0, 1'b1, 1'b0));
    send_vertex(vtx(24'sd3, 24'sd4, 24'sd5, 1'b0, 1'b0, 1'b1));
    drain();

    program_regs(unit_setting(), 1'b0);
    send_vertex(vtx(24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, 1'b1));
    // full coordinate span clamps to the largest size
    send_vertex(vtx(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0, 1'b0));
    send_vertex(vtx(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b0, 1'b1));
    // skipped vertex carrying the last flag still closes the face
    send_vertex(vtx(24'sd12295, -24'sd8192, 24'sd5, 1'b0, 1'b0, 1'b0));
    send_vertex(vtx(COORD_MAX, COORD_MIN, 24'sd0, 1'b1, 1'b0, 1'b0));
    send_vertex(vtx(-24'sd4097, 24'sd40960, 24'sd0, 1'b0, 1'b0, 1'b0));
    send_vertex(vtx(COORD_MIN, COORD_MAX, 24'sd9, 1'b1, 1'b0, 1'b1));
    // invalid face mid-face discards what was gathered
    send_vertex(vtx(24'sd1, 24'sd2, 24'sd3, 1'b0, 1'b0, 1'b0));
    send_vertex(vtx(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1, 1'b1));
    send_vertex(vtx(-24'sd5, 24'sd7, 24'sd0, 1'b0, 1'b0, 1'b1));
    send_vertex(vtx(24'sd4095, 24'sd4096, 24'sd0, 1'b0, 1'b0, 1'b1));
    drain();

    program_regs(random_setting(1'b1), 1'b0);
    random_run(100);
    drain();
    program_regs(extreme_setting(1'b0), 1'b0);
    random_run(100);
    drain();
    program_regs(extreme_setting(1'b1), 1'b1);
    random_run(100);
    drain();
    program_regs(random_setting(1'b0), 1'b1);
    random_run(50);
    // sender holds off until everything has come back
    drain();
    random_run(50);
    drain();
    program_regs(random_setting(1'b1), 1'b0);
    random_run(100);
    drain();
    calm = 1'b1;
    program_regs(unit_setting(), 1'b0);
    random_run(100);
    drain();

    $display("%0d vertices under %0d register settings, %0d extents checked, %0d mismatches",
             items_sent, settings_used, board.extents_seen, board.mismatches);
    $display("covered invalid and empty faces, skipped last vertices and size clamping");
    if (board.mismatches == 0 && board.due_extents.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: lightmap_extent_calculator_top.f
hw/rtl/lec_pkg.sv
hw/rtl/lec_front.sv
hw/rtl/lec_queue.sv
hw/rtl/lec_back.sv
hw/rtl/lightmap_extent_calculator_top.sv
test/testbench.sv
